[rtl/spcc_pkg.sv]
// Shared types and constants of the stepper position command controller.
package spcc_pkg;

  // Command kinds carried by a pushed command.
  localparam logic [1:0] CMD_CALIB = 2'd0;
  localparam logic [1:0] CMD_GOTO  = 2'd1;
  localparam logic [1:0] CMD_WAIT  = 2'd2;
  localparam logic [1:0] CMD_SPEED = 2'd3;

  // Motion state codes as reported on the result channel.
  localparam logic [1:0] MS_CALIB = 2'd0;
  localparam logic [1:0] MS_IDLE  = 2'd1;
  localparam logic [1:0] MS_WAIT  = 2'd2;
  localparam logic [1:0] MS_MOVE  = 2'd3;

  // Input mode codes.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_PUSH = 1'b1;

  localparam logic [15:0] DEFAULT_STEP_DELAY = 16'd500;

  // Speed command numerator and the quotient bits its division needs.
  localparam int unsigned SPEED_NUM = 32;
  localparam int unsigned DIV_BITS  = $clog2(SPEED_NUM + 1);

  typedef struct packed {
    logic        mode;
    logic [1:0]  command_kind;
    logic [15:0] command_value;
    logic        detector_active;
  } spcc_in_t;

  typedef struct packed {
    logic        step_left;
    logic        step_right;
    logic [1:0]  machine_state;
    logic [15:0] current_position;
    logic [15:0] target_position;
    logic        command_dropped;
  } spcc_out_t;

endpackage

[rtl/spcc_if.sv]
// Valid/ready channel interfaces for the controller's input and result items.
interface spcc_in_if
  import spcc_pkg::*;
;
  logic     valid;
  logic     ready;
  spcc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spcc_out_if
  import spcc_pkg::*;
;
  logic      valid;
  logic      ready;
  spcc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/stepper_position_command_controller.sv]
// A push or a counting tick passes from the accept state to the finish state,
// which loads the output register; a tick that runs a state step passes through
// the step state first, and a speed command also runs the restoring divider.
// Throughput: one item at a time; a new item is taken once the result is in
// the output register. Reset is asynchronous, active low, and clears the
// queue, the positions, the countdown and the motion state to calibrating.
module stepper_position_command_controller
  import spcc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 12,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  spcc_in_if.sink       in_i,
  spcc_out_if.source    out_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned DivCntW = $clog2(DIV_BITS + 1);
  localparam logic [DIV_BITS-1:0] DivDividend = DIV_BITS'(SPEED_NUM);

  typedef enum logic [1:0] {
    SQ_ACCEPT,
    SQ_STEP,
    SQ_DIV,
    SQ_FINISH
  } seq_e;

  seq_e                     seq_q;
  logic [1:0]               mstate_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] goal_q;
  logic [15:0]              step_delay_q;
  logic                     speed_taken_q;
  logic [16:0]              countdown_q;
  logic [CntW-1:0]          count_q;
  logic [PtrW-1:0]          head_q;
  logic [PtrW-1:0]          tail_q;
  logic                     det_q;
  logic                     left_q;
  logic                     right_q;
  logic                     drop_q;
  logic                     out_valid_q;
  spcc_out_t                out_q;

  logic [17:0]              mem [QUEUE_DEPTH];
  logic [17:0]              mem_rdata_q;

  logic [DIV_BITS-1:0]      div_dvd_q;
  logic [DIV_BITS-1:0]      div_quo_q;
  logic [16:0]              div_rem_q;
  logic [15:0]              div_den_q;
  logic [DivCntW-1:0]       div_cnt_q;

  logic        in_xfer;
  logic        push_wr;
  logic        step_to_div;
  logic [1:0]  rd_kind;
  logic [15:0] rd_value;
  logic [16:0] rem_shift;
  logic        rem_ge;
  logic [16:0] rem_next;
  logic [DIV_BITS-1:0] quo_next;
  logic [16:0] reload_plain;
  logic [16:0] reload_wait;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_i.ready = (seq_q == SQ_ACCEPT);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign push_wr    = in_xfer && (in_i.data.mode == MODE_PUSH)
                      && (count_q != CntW'(QUEUE_DEPTH));

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign rd_kind  = mem_rdata_q[17:16];
  assign rd_value = mem_rdata_q[15:0];

  // An idle step that pops a nonzero speed command hands over to the divider.
  assign step_to_div = (mstate_q == MS_IDLE) && (pos_q == goal_q) && (count_q != '0)
                       && (rd_kind == CMD_SPEED) && (rd_value != '0);

  // One restoring division step: shift in the next dividend bit and subtract.
  assign rem_shift = {div_rem_q[15:0], div_dvd_q[DIV_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_den_q};
  assign rem_next  = rem_ge ? (rem_shift - {1'b0, div_den_q}) : rem_shift;
  assign quo_next  = {div_quo_q[DIV_BITS-2:0], rem_ge};

  assign reload_plain = {1'b0, step_delay_q};
  assign reload_wait  = {1'b0, step_delay_q} + {1'b0, rd_value};

  // Command queue storage with a registered read port at the head.
  always_ff @(posedge clk_i) begin
    if (push_wr) begin
      mem[tail_q] <= {in_i.data.command_kind, in_i.data.command_value};
    end
    mem_rdata_q <= mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= SQ_ACCEPT;
      mstate_q      <= MS_CALIB;
      pos_q         <= '0;
      goal_q        <= '0;
      step_delay_q  <= DEFAULT_STEP_DELAY;
      speed_taken_q <= 1'b0;
      countdown_q   <= '0;
      count_q       <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      det_q         <= 1'b0;
      left_q        <= 1'b0;
      right_q       <= 1'b0;
      drop_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
      div_dvd_q     <= '0;
      div_quo_q     <= '0;
      div_rem_q     <= '0;
      div_den_q     <= '0;
      div_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (!speed_taken_q) begin
          step_delay_q <= cfg_wdata_i;
        end
      end

      if (out_valid_q && out_o.ready && (seq_q != SQ_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      case (seq_q)
        SQ_ACCEPT: begin
          if (in_xfer) begin
            det_q   <= in_i.data.detector_active;
            left_q  <= 1'b0;
            right_q <= 1'b0;
            drop_q  <= (in_i.data.mode == MODE_PUSH) && !push_wr;
            if (in_i.data.mode == MODE_PUSH) begin
              seq_q <= SQ_FINISH;
              if (push_wr) begin
                tail_q  <= ptr_inc(tail_q);
                count_q <= count_q + 1'b1;
              end
            end else if (countdown_q != '0) begin
              seq_q       <= SQ_FINISH;
              countdown_q <= countdown_q - 1'b1;
            end else begin
              seq_q <= SQ_STEP;
            end
          end
        end
        SQ_STEP: begin
          seq_q <= step_to_div ? SQ_DIV : SQ_FINISH;
          case (mstate_q)
            MS_CALIB: begin
              if (det_q) begin
                pos_q    <= '0;
                goal_q   <= '0;
                mstate_q <= MS_IDLE;
              end else begin
                left_q <= 1'b1;
              end
              countdown_q <= reload_plain;
            end
            MS_IDLE: begin
              if (pos_q != goal_q) begin
                mstate_q    <= MS_MOVE;
                countdown_q <= reload_plain;
              end else if (count_q != '0) begin
                // The idle check with an empty queue leaves the countdown at zero.
                head_q  <= ptr_inc(head_q);
                count_q <= count_q - 1'b1;
                case (rd_kind)
                  CMD_CALIB: begin
                    mstate_q    <= MS_CALIB;
                    countdown_q <= reload_plain;
                  end
                  CMD_GOTO: begin
                    goal_q      <= POSITION_BITS'(rd_value);
                    countdown_q <= reload_plain;
                  end
                  CMD_WAIT: begin
                    mstate_q    <= MS_WAIT;
                    countdown_q <= reload_wait;
                  end
                  default: begin
                    if (rd_value != '0) begin
                      div_dvd_q <= DivDividend;
                      div_quo_q <= '0;
                      div_rem_q <= '0;
                      div_den_q <= rd_value;
                      div_cnt_q <= DivCntW'(DIV_BITS);
                    end else begin
                      countdown_q <= reload_plain;
                    end
                  end
                endcase
              end
            end
            MS_WAIT: begin
              mstate_q    <= MS_IDLE;
              countdown_q <= reload_plain;
            end
            default: begin
              if (pos_q == goal_q) begin
                mstate_q <= MS_IDLE;
              end else if (pos_q < goal_q) begin
                right_q <= 1'b1;
                pos_q   <= pos_q + 1'b1;
              end else begin
                left_q <= 1'b1;
                pos_q  <= pos_q - 1'b1;
              end
              countdown_q <= reload_plain;
            end
          endcase
        end
        SQ_DIV: begin
          div_rem_q <= rem_next;
          div_quo_q <= quo_next;
          div_dvd_q <= {div_dvd_q[DIV_BITS-2:0], 1'b0};
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == DivCntW'(1)) begin
            step_delay_q  <= 16'(quo_next);
            speed_taken_q <= 1'b1;
            countdown_q   <= 17'(quo_next);
            seq_q         <= SQ_FINISH;
          end
        end
        SQ_FINISH: begin
          // The result waits here until the previous one has been taken.
          if (!out_valid_q || out_o.ready) begin
            out_q.step_left        <= left_q;
            out_q.step_right       <= right_q;
            out_q.machine_state    <= mstate_q;
            out_q.current_position <= 16'(pos_q);
            out_q.target_position  <= 16'(goal_q);
            out_q.command_dropped  <= drop_q;
            out_valid_q            <= 1'b1;
            seq_q                  <= SQ_ACCEPT;
          end
        end
        default: seq_q <= SQ_ACCEPT;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("command queue count exceeds its depth");

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.step_left && out_q.step_right))
    else $error("step pulses in both directions at once");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.data.mode == MODE_PUSH && count_q == CntW'(QUEUE_DEPTH))
      |=> (drop_q && count_q == CntW'(QUEUE_DEPTH)))
    else $error("push into a full queue was not dropped");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_DIV && div_cnt_q == DivCntW'(1))
      |=> (step_delay_q <= 16'(SPEED_NUM) && seq_q == SQ_FINISH))
    else $error("speed quotient out of range");

  a_drop_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.command_dropped) |-> !(out_q.step_left || out_q.step_right))
    else $error("dropped push produced a step pulse");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the stepper position command controller.
module testbench;
  import spcc_pkg::*;

  localparam int FIFO_SLOTS = 12;
  localparam int POS_BITS   = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
  } queued_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  spcc_in_if  in_ch ();
  spcc_out_if out_ch ();

  stepper_position_command_controller #(
    .QUEUE_DEPTH   (FIFO_SLOTS),
    .POSITION_BITS (POS_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted controller state.
  logic [1:0]  ctl_state      = MS_CALIB;
  logic [15:0] ctl_pos        = '0;
  logic [15:0] ctl_goal       = '0;
  logic [15:0] ctl_step_delay = DEFAULT_STEP_DELAY;
  logic [16:0] ctl_countdown  = '0;
  bit          ctl_speed_set  = 1'b0;
  queued_cmd_t ctl_fifo[$];

  spcc_in_t  pending_items[$];
  spcc_out_t expected_status[$];

  int fail_count   = 0;
  int results_seen = 0;
  int idle_max     = 14;
  int gap_cycles   = 0;
  int hold_cycles  = 0;

  // Stimulus planning: a rough guess of where the motor is heading and how
  // many ticks the queued work still needs.
  int          queued_total = 0;
  int          est_pos      = 0;
  int unsigned est_delay    = DEFAULT_STEP_DELAY;
  bit          est_speed    = 1'b0;
  bit          speed_ok     = 1'b0;
  int unsigned owed_ticks   = 0;

  function automatic spcc_out_t advance_controller(input spcc_in_t item);
    spcc_out_t   res;
    queued_cmd_t cmd;
    logic [16:0] extra;
    bit          ran;
    res   = '0;
    extra = '0;
    ran   = 1'b1;
    if (item.mode == MODE_PUSH) begin
      if (ctl_fifo.size() >= FIFO_SLOTS) begin
        res.command_dropped = 1'b1;
      end else begin
        cmd.kind  = item.command_kind;
        cmd.value = item.command_value;
        ctl_fifo.push_back(cmd);
      end
    end else if (ctl_countdown != 0) begin
      ctl_countdown = ctl_countdown - 1'b1;
    end else begin
      case (ctl_state)
        MS_CALIB: begin
          if (item.detector_active) begin
            ctl_pos   = '0;
            ctl_goal  = '0;
            ctl_state = MS_IDLE;
          end else begin
            res.step_left = 1'b1;
          end
        end
        MS_IDLE: begin
          if (ctl_pos != ctl_goal) begin
            ctl_state = MS_MOVE;
          end else if (ctl_fifo.size() == 0) begin
            // Nothing to do: the countdown stays at zero so the next tick
            // looks at the queue again.
            ran = 1'b0;
          end else begin
            cmd = ctl_fifo.pop_front();
            case (cmd.kind)
              CMD_CALIB: ctl_state = MS_CALIB;
              CMD_GOTO:  ctl_goal = cmd.value;
              CMD_WAIT: begin
                ctl_state = MS_WAIT;
                extra     = {1'b0, cmd.value};
              end
              default: begin
                if (cmd.value != 0) begin
                  ctl_step_delay = 16'(SPEED_NUM / 32'(cmd.value));
                  ctl_speed_set  = 1'b1;
                end
              end
            endcase
          end
        end
        MS_WAIT: ctl_state = MS_IDLE;
        default: begin
          if (ctl_pos == ctl_goal) begin
            ctl_state = MS_IDLE;
          end else if (ctl_pos < ctl_goal) begin
            res.step_right = 1'b1;
            ctl_pos        = ctl_pos + 1'b1;
          end else begin
            res.step_left = 1'b1;
            ctl_pos       = ctl_pos - 1'b1;
          end
        end
      endcase
      if (ran) ctl_countdown = {1'b0, ctl_step_delay} + extra;
    end
    res.machine_state    = ctl_state;
    res.current_position = ctl_pos;
    res.target_position  = ctl_goal;
    return res;
  endfunction

  // Sender: one item per transfer, with a random gap after each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      gap_cycles = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_status.push_back(advance_controller(in_ch.data));
        gap_cycles = $urandom_range(0, idle_max);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_cycles > 0) begin
          gap_cycles--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_items.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares every result transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    spcc_out_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with nothing expected: %p", results_seen,
                     out_ch.data);
        end else begin
          want = expected_status.pop_front();
          if (out_ch.data.step_left !== want.step_left ||
              out_ch.data.step_right !== want.step_right ||
              out_ch.data.machine_state !== want.machine_state ||
              out_ch.data.current_position !== want.current_position ||
              out_ch.data.target_position !== want.target_position ||
              out_ch.data.command_dropped !== want.command_dropped) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d mismatch: expected %p, got %p", results_seen, want,
                       out_ch.data);
          end
        end
        hold_cycles = $urandom_range(0, idle_max);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic mode, input logic [1:0] kind,
                            input logic [15:0] value, input logic det);
    spcc_in_t item;
    item.mode            = mode;
    item.command_kind    = kind;
    item.command_value   = value;
    item.detector_active = det;
    pending_items.push_back(item);
    queued_total++;
  endtask

  // Ticks carry random command fields, which the block must ignore.
  task automatic add_ticks(input int unsigned count);
    repeat (count)
      queue_item(MODE_TICK, 2'($urandom), 16'($urandom), $urandom_range(0, 9) < 3);
  endtask

  task automatic flush_owed();
    int unsigned count;
    count = owed_ticks + $urandom_range(0, 3);
    if (count > 400) count = 400;
    add_ticks(count);
    owed_ticks = 0;
  endtask

  // Pushes one command whose work stays short, and books the ticks it needs.
  task automatic add_command(input bit cheap);
    int unsigned pick;
    int unsigned step;
    int          span;
    int          target;
    logic [1:0]  kind;
    logic [15:0] val;
    step = est_delay + 1;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      kind = CMD_CALIB;
      val  = 16'($urandom);
      est_pos = 0;
      owed_ticks += 6 * step;
    end else if (pick < 55) begin
      kind   = CMD_GOTO;
      span   = cheap ? 2 : 12;
      target = est_pos + int'($urandom_range(0, 2 * span)) - span;
      if (target < 0) target = 0;
      if (target > 65535) target = 65535;
      owed_ticks += ((target > est_pos) ? target - est_pos : est_pos - target) * step;
      owed_ticks += 3 * step;
      est_pos = target;
      val     = 16'(target);
    end else if (pick < 80 || !speed_ok) begin
      kind = CMD_WAIT;
      if (cheap) val = 16'($urandom_range(0, 2));
      else if ($urandom_range(0, 9) == 0) val = 16'($urandom_range(0, 40));
      else val = 16'($urandom_range(0, 5));
      owed_ticks += val + 2 * step;
    end else begin
      kind = CMD_SPEED;
      pick = $urandom_range(0, 99);
      if (pick < 20) val = '0;
      else if (pick < 45) val = 16'($urandom_range(33, 65535));
      else if (pick < 50) val = 16'($urandom_range(1, 7));
      else val = 16'($urandom_range(8, 32));
      if (val != 0) begin
        est_delay = SPEED_NUM / val;
        est_speed = 1'b1;
      end
      owed_ticks += est_delay + 1;
    end
    owed_ticks += step;
    queue_item(MODE_PUSH, kind, val, 1'($urandom_range(0, 1)));
  endtask

  task automatic add_sequence();
    int unsigned pick;
    int unsigned count;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat ($urandom_range(1, 4)) add_command(1'b0);
      flush_owed();
    end else if (pick < 85) begin
      count = $urandom_range(1, 8);
      add_ticks(count);
      owed_ticks = (owed_ticks > count) ? owed_ticks - count : 0;
    end else if (pick < 93) begin
      // A burst long enough to overrun the queue.
      repeat ($urandom_range(13, 15)) add_command(1'b1);
      flush_owed();
    end else begin
      // Commands with no ticks to run them.
      repeat ($urandom_range(1, 2)) add_command(1'b0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_items.size() > 0 || in_ch.valid || expected_status.size() > 0)
      @(negedge clk_i);
  endtask

  task automatic write_step_delay(input logic [15:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    if (!ctl_speed_set) ctl_step_delay = value;
    if (!est_speed) est_delay = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int          phase_end;
    logic [15:0] phase_delay [5];
    int          phase_idle  [5];
    phase_delay = '{16'd1, 16'd3, 16'd2, 16'd0, 16'd4};
    phase_idle  = '{14, 0, 14, 14, 14};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the queue while the delay is at its largest, so nothing runs yet.
    write_step_delay(16'hFFFF);
    queue_item(MODE_PUSH, CMD_WAIT, 16'd3, 1'b0);
    queue_item(MODE_PUSH, CMD_SPEED, 16'd0, 1'b1);
    queue_item(MODE_PUSH, CMD_GOTO, 16'd2, 1'b0);
    queue_item(MODE_PUSH, CMD_GOTO, 16'd2, 1'b1);
    queue_item(MODE_PUSH, CMD_GOTO, 16'd0, 1'b0);
    queue_item(MODE_PUSH, CMD_CALIB, 16'hFFFF, 1'b1);
    queue_item(MODE_PUSH, CMD_GOTO, 16'd1, 1'b0);
    queue_item(MODE_PUSH, CMD_WAIT, 16'd0, 1'b1);
    queue_item(MODE_PUSH, CMD_GOTO, 16'd3, 1'b0);
    queue_item(MODE_PUSH, CMD_WAIT, 16'd1, 1'b1);
    queue_item(MODE_PUSH, CMD_CALIB, 16'h0000, 1'b0);
    queue_item(MODE_PUSH, CMD_GOTO, 16'd3, 1'b1);
    // The queue is full now, so these two are dropped.
    queue_item(MODE_PUSH, CMD_GOTO, 16'hFFFF, 1'b1);
    queue_item(MODE_PUSH, CMD_SPEED, 16'hFFFF, 1'b0);

    write_step_delay(16'd0);
    queue_item(MODE_TICK, 2'd3, 16'hFFFF, 1'b0);
    queue_item(MODE_TICK, 2'd0, 16'h0000, 1'b0);
    queue_item(MODE_TICK, 2'd1, 16'h5555, 1'b1);
    add_ticks(7);
    est_pos    = 3;
    owed_ticks = 60;

    for (int p = 0; p < 5; p++) begin
      write_step_delay(phase_delay[p]);
      idle_max  = phase_idle[p];
      speed_ok  = (p >= 2);
      phase_end = queued_total + 385;
      while (queued_total < phase_end) add_sequence();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
